/* hw/rtl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, codes and defaults for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int MAX_BLOCKS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	localparam int OP_W     = 2;
	localparam int IDX_W    = 4;
	localparam int FIELD_W  = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [IDX_W-1:0]   block_index;
		logic [FIELD_W-1:0] size_value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    chosen_block;
		logic [FIELD_W-1:0]  free_left;
		logic [FIELD_W-1:0]  initial_size;
	} rsp_t;

endpackage

/* hw/rtl/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a table of blocks held in one RAM (loaded size and
// free space per entry); configurable count of blocks in use.
// ----------------------------------------------------------------------------
// Path (accept to out_valid): load, out-of-range and empty-table allocate go
//   to DONE at once, read via RDWAIT, allocate scans until a fit or n blocks.
// Requests: one at a time, taken again the cycle after the result moves to
//   the output register.
// Reset: arst_n clears control, sets block_count to 16, then a clearing pass
//   zeroes the table before the first request is taken.
module first_fit_block_allocator #(
	parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = ffba_pkg::SIZE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ffba_pkg::COUNT_W-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ffba_pkg::req_t                in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ffba_pkg::rsp_t                out_data
);

	localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int DW = 2 * SIZE_BITS;

	logic [ffba_pkg::COUNT_W-1:0] block_count_q;
	logic                         out_valid_q;
	ffba_pkg::rsp_t               out_data_q;

	logic                         rsp_free, done;
	ffba_pkg::rsp_t               rsp;
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr, ram_raddr;
	logic [DW-1:0]                ram_wdata, ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= ffba_pkg::BLOCK_COUNT_RST;
		end else if (cfg_valid) begin
			block_count_q <= cfg_data;
		end
	end

	assign rsp_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_free) begin
			out_valid_q <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_free && done) begin
			out_data_q <= rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	ffba_seq #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.block_count (block_count_q),
		.rsp_free    (rsp_free),
		.done        (done),
		.rsp         (rsp),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	ffba_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

/* hw/rtl/ffba_ram.sv */
// ----------------------------------------------------------------------------
// ffba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/ffba_seq.sv */
// ----------------------------------------------------------------------------
// ffba_seq
// Sequencer for the allocator: clearing pass, load/read, and the first-fit
// scan through one shared compare/subtract unit, one table entry per cycle.
// ----------------------------------------------------------------------------
module ffba_seq #(
	parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = ffba_pkg::SIZE_BITS_DEF,
	localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
	localparam int CW = ($clog2(MAX_BLOCKS + 1) > ffba_pkg::COUNT_W) ?
		$clog2(MAX_BLOCKS + 1) : ffba_pkg::COUNT_W,
	localparam int DW = 2 * SIZE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  ffba_pkg::req_t                       in_data,
	input  logic [ffba_pkg::COUNT_W-1:0]         block_count,
	input  logic                                 rsp_free,
	output logic                                 done,
	output ffba_pkg::rsp_t                       rsp,
	output logic                                 ram_we,
	output logic [AW-1:0]                        ram_waddr,
	output logic [DW-1:0]                        ram_wdata,
	output logic [AW-1:0]                        ram_raddr,
	input  logic [DW-1:0]                        ram_rdata
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_RDWAIT = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BLOCKS - 1);
	localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_BLOCKS);

	logic [2:0]                        state_q, state_d;
	logic [AW-1:0]                     cnt_q, cnt_d;
	logic [ffba_pkg::IDX_W-1:0]        idx_q;
	logic [SIZE_BITS-1:0]              sz_q;
	logic [CW-1:0]                     n_q;
	ffba_pkg::rsp_t                    res_q, res_d;

	logic [CW-1:0]                     bc_ext, n_in, idx_ext;
	logic [AW-1:0]                     idx_addr;
	logic [SIZE_BITS-1:0]              sz_in;
	logic [SIZE_BITS-1:0]              rd_free, rd_init, diff;
	logic                              fit, accept;

	assign bc_ext   = CW'(block_count);
	assign n_in     = (bc_ext > MAX_CNT) ? MAX_CNT : bc_ext;
	assign idx_ext  = CW'(in_data.block_index);
	assign idx_addr = AW'(in_data.block_index);
	assign sz_in    = SIZE_BITS'(in_data.size_value);

	assign rd_init = ram_rdata[DW-1:SIZE_BITS];
	assign rd_free = ram_rdata[SIZE_BITS-1:0];

	// shared compare/subtract unit
	assign fit  = rd_free >= sz_q;
	assign diff = rd_free - sz_q;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign done     = (state_q == S_DONE);
	assign rsp      = res_q;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		res_d     = res_q;
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		ram_raddr = cnt_q + AW'(1);
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				cnt_d  = cnt_q + AW'(1);
				if (cnt_q == LAST_ADDR) begin
					cnt_d   = '0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				ram_raddr = (in_data.operation == ffba_pkg::OP_ALLOC) ? '0 : idx_addr;
				if (in_valid) begin
					cnt_d = '0;
					if (in_data.operation == ffba_pkg::OP_ALLOC) begin
						if (n_in == '0) begin
							res_d   = '{ffba_pkg::ST_NOFIT, '0, '0, '0};
							state_d = S_DONE;
						end else begin
							state_d = S_SCAN;
						end
					end else if (idx_ext >= n_in) begin
						res_d   = '{ffba_pkg::ST_RANGE, in_data.block_index, '0, '0};
						state_d = S_DONE;
					end else if (in_data.operation == ffba_pkg::OP_LOAD) begin
						ram_we    = 1'b1;
						ram_waddr = idx_addr;
						ram_wdata = {sz_in, sz_in};
						res_d     = '{ffba_pkg::ST_OK, in_data.block_index,
							ffba_pkg::FIELD_W'(sz_in), ffba_pkg::FIELD_W'(sz_in)};
						state_d   = S_DONE;
					end else begin
						state_d = S_RDWAIT;
					end
				end
			end
			S_SCAN: begin
				if (fit) begin
					ram_we    = 1'b1;
					ram_waddr = cnt_q;
					ram_wdata = {rd_init, diff};
					res_d     = '{ffba_pkg::ST_OK, ffba_pkg::IDX_W'(cnt_q),
						ffba_pkg::FIELD_W'(diff), ffba_pkg::FIELD_W'(rd_init)};
					state_d   = S_DONE;
				end else if (CW'(cnt_q) + CW'(1) == n_q) begin
					res_d   = '{ffba_pkg::ST_NOFIT, '0, '0, '0};
					state_d = S_DONE;
				end else begin
					// advance; next entry is already being read
					cnt_d = cnt_q + AW'(1);
				end
			end
			S_RDWAIT: begin
				res_d   = '{ffba_pkg::ST_OK, idx_q,
					ffba_pkg::FIELD_W'(rd_free), ffba_pkg::FIELD_W'(rd_init)};
				state_d = S_DONE;
			end
			S_DONE: begin
				// hold until the output register can take the result
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (accept) begin
			idx_q <= in_data.block_index;
			sz_q  <= sz_in;
			n_q   <= n_in;
		end
	end

`ifndef SYNTHESIS
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (CW'(cnt_q) < n_q))
		else $error("scan index beyond block count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("request taken while previous one still in work");

	a_write_only_on_fit: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q == S_SCAN) |-> (rd_free >= sz_q))
		else $error("allocation write without a fitting block");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp_free) |=> (done && $stable(res_q)))
		else $error("result dropped while output register busy");
`endif

endmodule
